// ===== hdl/lrukvc_pkg.sv =====
package lrukvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int EFF_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 31;
  localparam int RESULT_W  = 32;
  localparam int IN_DATA_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [ENTRIES-1:0]  entry_vec_t;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Channel       | Direction | Ports                          | Contents
// s_axis        | in        | tvalid, tready, tdata, tuser   | request: func, key, value
// m_axis        | out       | tvalid, tready, tdata, tuser   | get result: found, read_value
// cfg           | in        | cfg_wr_en, cfg_wr_data         | capacity register
//
// One request word is taken per cycle unless a get waits; a result passes input then output register.
// The rate is set by the single pass of the parallel key compare and rank update on the table.
// Reset clears all valid bits and the entry count and sets the capacity to sixteen.
// A get waits in the input register while an untaken result holds the output register.
// A put gives no result and so never waits on the output side.
module lru_key_value_cache
  import lrukvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // key[31:0], value[62:32], zero[63]
  input  logic                 s_axis_tuser,  // func[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RESULT_W-1:0]  m_axis_tdata,  // read_value[31:0]
  output logic                 m_axis_tuser   // found[0]
);

  logic [CAP_W-1:0] capacity;

  logic   in_valid;
  func_t  in_func;
  key_t   in_key;
  value_t in_value;

  logic               out_valid;
  logic               out_found;
  logic [RESULT_W-1:0] out_value;

  key_t       keys  [ENTRIES];
  value_t     vals  [ENTRIES];
  rank_t      ranks [ENTRIES];
  entry_vec_t valid;
  count_t     in_use;

  logic       fire;
  entry_vec_t hit;
  logic       any_hit;
  value_t     hit_value;
  rank_t      hit_rank;
  entry_vec_t evict_vec;
  entry_vec_t first_free;
  entry_vec_t ins_vec;
  entry_vec_t valid_kept;
  logic       do_evict;
  logic       do_insert;
  logic       do_touch;
  logic [EFF_W-1:0] eff_cap;

  rank_t      ranks_next [ENTRIES];
  entry_vec_t valid_next;
  count_t     in_use_next;

  assign fire = in_valid && (in_func == FUNC_PUT || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_comb begin
    eff_cap = (capacity == '0) ? EFF_W'(1) : EFF_W'(capacity);
    if (eff_cap > EFF_W'(ENTRIES)) begin
      eff_cap = EFF_W'(ENTRIES);
    end
  end

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i]       = valid[i] && (keys[i] == in_key);
      evict_vec[i] = valid[i] && (CNT_W'(ranks[i]) == in_use - CNT_W'(1));
      if (hit[i]) begin
        hit_value = hit_value | vals[i];
        hit_rank  = hit_rank | ranks[i];
      end
    end
  end

  assign any_hit    = |hit;
  assign first_free = ~valid & (valid + entry_vec_t'(1));
  assign do_evict   = (EFF_W'(in_use) >= eff_cap) && (in_use != '0);
  assign do_insert  = fire && in_func == FUNC_PUT && !any_hit;
  assign do_touch   = fire && any_hit;
  assign ins_vec    = do_evict ? evict_vec : first_free;
  assign valid_kept = do_evict ? (valid & ~evict_vec) : valid;

  always_comb begin
    valid_next  = valid;
    in_use_next = in_use;
    for (int i = 0; i < ENTRIES; i++) begin
      ranks_next[i] = ranks[i];
      if (do_touch) begin
        if (hit[i]) begin
          ranks_next[i] = '0;
        end else if (valid[i] && ranks[i] < hit_rank) begin
          ranks_next[i] = ranks[i] + rank_t'(1);
        end
      end else if (do_insert) begin
        if (ins_vec[i]) begin
          ranks_next[i] = '0;
        end else if (valid_kept[i]) begin
          ranks_next[i] = ranks[i] + rank_t'(1);
        end
      end
    end
    if (do_insert) begin
      valid_next = valid_kept | ins_vec;
      if (!do_evict) begin
        in_use_next = in_use + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      valid     <= '0;
      in_use    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (fire && in_func == FUNC_GET) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      valid  <= valid_next;
      in_use <= in_use_next;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= ranks_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func  <= func_t'(s_axis_tuser);
      in_key   <= s_axis_tdata[KEY_W-1:0];
      in_value <= s_axis_tdata[KEY_W +: VALUE_W];
    end
    if (fire && in_func == FUNC_GET) begin
      out_found <= any_hit;
      out_value <= any_hit ? {1'b0, hit_value} : '1;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_insert && ins_vec[i]) begin
        keys[i] <= in_key;
        vals[i] <= in_value;
      end else if (fire && in_func == FUNC_PUT && hit[i]) begin
        vals[i] <= in_value;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_found;

  a_single_hit : assert property (@(posedge clk) disable iff (rst)
    in_valid |-> $onehot0(hit))
    else $error("more than one entry matches the key");

  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(in_use))
    else $error("entry count disagrees with valid bits");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    in_use <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_get_result : assert property (@(posedge clk) disable iff (rst)
    (fire && in_func == FUNC_GET) |=> m_axis_tvalid)
    else $error("get did not produce a result word");

endmodule
